/* rtl/matrix4x4_multiply_unit_macros.svh */
// Assertion macros shared by the 4x4 matrix multiply unit RTL.
// Relies on signals named clock and reset in the module that uses them.
`ifndef MATRIX4X4_MULTIPLY_UNIT_MACROS_SVH
`define MATRIX4X4_MULTIPLY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication checked at every rising clock edge outside reset.
`define MM4_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mm4 same-cycle check failed");
// Next-cycle implication checked at every rising clock edge outside reset.
`define MM4_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mm4 next-cycle check failed");
`else
`define MM4_ASSERT_IMPL(label, ante, cons)
`define MM4_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/mm4_pkg.sv */
// Shared constants and types of the 4x4 matrix multiply unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package mm4_pkg;
   localparam int DIM               = 4;
   localparam int CELLS             = DIM * DIM;
   localparam int IDX_W             = $clog2(CELLS);
   localparam int LADDR_W           = $clog2(DIM);
   localparam int ELEM_W            = 32;
   localparam int PROD_W            = 2 * ELEM_W;
   localparam int PAIR_W            = PROD_W + 1;
   localparam int SUM_W             = PROD_W + 2;
   localparam int FRAC_BITS_DEFAULT = 16;

   // Write control of one lane's two element banks.
   typedef struct packed {
      logic               left_we;
      logic               right_we;
      logic [LADDR_W-1:0] left_addr;
      logic [LADDR_W-1:0] right_addr;
   } mm4_wr_type;

   // Read and pipeline-advance control of one lane.
   typedef struct packed {
      logic               advance;
      logic [LADDR_W-1:0] left_addr;
      logic [LADDR_W-1:0] right_addr;
   } mm4_rd_type;
endpackage

/* rtl/mm4_lane.sv */
// One multiply lane: a left bank and a right bank of four elements each,
// a registered read and a registered signed product. Depends on mm4_pkg.
`timescale 1ns / 1ps
module mm4_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  mm4_pkg::mm4_wr_type                 wr,
   input  logic signed [mm4_pkg::ELEM_W-1:0]   left_data,
   input  logic signed [mm4_pkg::ELEM_W-1:0]   right_data,
   input  mm4_pkg::mm4_rd_type                 rd,
   output logic signed [mm4_pkg::PROD_W-1:0]   product
);
   import mm4_pkg::*;

   logic signed [ELEM_W-1:0] left_mem  [DIM];
   logic signed [ELEM_W-1:0] right_mem [DIM];
   logic [DIM-1:0]           left_vld_ff, left_vld_in;
   logic [DIM-1:0]           right_vld_ff, right_vld_in;
   logic signed [ELEM_W-1:0] left_rd_ff, right_rd_ff;
   logic                     left_rdv_ff, right_rdv_ff;
   logic signed [ELEM_W-1:0] left_op, right_op;
   logic signed [PROD_W-1:0] product_ff, product_in;

   // Bank writes; an entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (wr.left_we) begin
         left_mem[wr.left_addr] <= left_data;
      end
      if (wr.right_we) begin
         right_mem[wr.right_addr] <= right_data;
      end
   end

   always_comb begin
      left_vld_in  = left_vld_ff | ({DIM{wr.left_we}} & (DIM'(1) << wr.left_addr));
      right_vld_in = right_vld_ff | ({DIM{wr.right_we}} & (DIM'(1) << wr.right_addr));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_vld_ff  <= '0;
         right_vld_ff <= '0;
      end else begin
         left_vld_ff  <= left_vld_in;
         right_vld_ff <= right_vld_in;
      end
   end

   // Registered bank reads, held while the pipeline stalls.
   always_ff @(posedge clock) begin
      if (rd.advance) begin
         left_rd_ff   <= left_mem[rd.left_addr];
         right_rd_ff  <= right_mem[rd.right_addr];
         left_rdv_ff  <= left_vld_ff[rd.left_addr];
         right_rdv_ff <= right_vld_ff[rd.right_addr];
      end
   end

   // Signed 32 x 32 product into a 64-bit register.
   always_comb begin
      left_op    = left_rdv_ff ? left_rd_ff : '0;
      right_op   = right_rdv_ff ? right_rd_ff : '0;
      product_in = left_op * right_op;
   end

   always_ff @(posedge clock) begin
      if (rd.advance) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;
endmodule

/* rtl/mm4_merge.sv */
// Merging stage: registered adder tree over the four lane products, then
// floor shift by the fraction width and saturation to 32 bits. Uses mm4_pkg.
`timescale 1ns / 1ps
module mm4_merge #(
   parameter int unsigned FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               advance,
   input  logic signed [mm4_pkg::PROD_W-1:0]  products [mm4_pkg::DIM],
   output logic signed [mm4_pkg::ELEM_W-1:0]  result
);
   import mm4_pkg::*;

   logic signed [PAIR_W-1:0] pair_ff [2];
   logic signed [PAIR_W-1:0] pair_in [2];
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [SUM_W-1:0]  shifted;
   logic [SUM_W-ELEM_W:0]    upper;

   // First level: two pairwise sums; second level: their total.
   always_comb begin
      pair_in[0] = PAIR_W'(products[0]) + PAIR_W'(products[1]);
      pair_in[1] = PAIR_W'(products[2]) + PAIR_W'(products[3]);
      sum_in     = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff <= pair_in;
         sum_ff  <= sum_in;
      end
   end

   // Floor shift, then clamp when the upper bits are not a sign extension.
   always_comb begin
      shifted = sum_ff >>> FRAC_BITS;
      upper   = shifted[SUM_W-1:ELEM_W-1];
      if ((&upper) || !(|upper)) begin
         result = shifted[ELEM_W-1:0];
      end else if (shifted[SUM_W-1]) begin
         result = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(ELEM_W-1){1'b1}}};
      end
   end
endmodule

/* rtl/matrix4x4_multiply_unit.sv */
// 4x4 signed Q16.16 matrix multiply. Sixteen load beats fill the stores, one
// per cycle while no run issues; the beat at index 15 starts a run of sixteen
// product beats. They pass the bank read, product, pair, sum and output
// registers, one beat per cycle through four multiply lanes unless the output
// stalls, and loads for the next run are taken while the pipeline drains.
// Synchronous active-high reset clears control and marks every store entry zero.
`timescale 1ns / 1ps
`include "matrix4x4_multiply_unit_macros.svh"
module matrix4x4_multiply_unit #(
   parameter int unsigned FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mm4_pkg::IDX_W-1:0]          req_element_index,
   input  logic signed [mm4_pkg::ELEM_W-1:0]  req_left_element,
   input  logic signed [mm4_pkg::ELEM_W-1:0]  req_right_element,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mm4_pkg::IDX_W-1:0]          rsp_product_index,
   output logic signed [mm4_pkg::ELEM_W-1:0]  rsp_product_element,
   output logic                               rsp_last_of_run
);
   import mm4_pkg::*;

   localparam int STAGES = 4;

   logic                     req_fire;
   logic                     advance;
   logic                     run_ff, run_in;
   logic [IDX_W-1:0]         cnt_ff, cnt_in;
   logic [STAGES-1:0]        s_vld_ff, s_vld_in;
   logic [IDX_W-1:0]         s_idx_ff [STAGES];
   logic signed [PROD_W-1:0] products [DIM];
   logic signed [ELEM_W-1:0] merged;
   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_index_ff;
   logic signed [ELEM_W-1:0] rsp_element_ff;
   logic                     rsp_last_ff;
   mm4_rd_type               rd;

   assign req_ready = !run_ff;
   assign req_fire  = req_valid && req_ready;
   assign advance   = !rsp_valid_ff || rsp_ready;

   // Issue sequencer: steps through the sixteen product indices.
   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      if (run_ff && advance) begin
         cnt_in = cnt_ff + IDX_W'(1);
         if (cnt_ff == IDX_W'(CELLS - 1)) begin
            run_in = 1'b0;
         end
      end else if (req_fire && req_element_index == IDX_W'(CELLS - 1)) begin
         run_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         cnt_ff <= cnt_in;
      end
   end

   // Row i selects the left address, column j the right address.
   always_comb begin
      rd.advance    = advance;
      rd.left_addr  = cnt_ff[IDX_W-1:LADDR_W];
      rd.right_addr = cnt_ff[LADDR_W-1:0];
   end

   // Lane k holds left[i+4k] at address i and right[4j+k] at address j.
   for (genvar k = 0; k < DIM; k++) begin : g_lane
      mm4_wr_type wr;

      always_comb begin
         wr.left_we    = req_fire && (req_element_index[IDX_W-1:LADDR_W] == LADDR_W'(k));
         wr.right_we   = req_fire && (req_element_index[LADDR_W-1:0] == LADDR_W'(k));
         wr.left_addr  = req_element_index[LADDR_W-1:0];
         wr.right_addr = req_element_index[IDX_W-1:LADDR_W];
      end

      mm4_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .wr         (wr),
         .left_data  (req_left_element),
         .right_data (req_right_element),
         .rd         (rd),
         .product    (products[k])
      );
   end

   mm4_merge #(
      .FRAC_BITS (FRAC_BITS)
   ) u_merge (
      .clock    (clock),
      .advance  (advance),
      .products (products),
      .result   (merged)
   );

   // Valid and index tags that travel beside the datapath stages.
   assign s_vld_in = {s_vld_ff[STAGES-2:0], run_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s_vld_ff <= '0;
      end else if (advance) begin
         s_vld_ff <= s_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_idx_ff[0] <= cnt_ff;
         for (int s = 1; s < STAGES; s++) begin
            s_idx_ff[s] <= s_idx_ff[s-1];
         end
      end
   end

   // Output register; it loads whenever the current beat is taken or absent.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s_vld_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_index_ff   <= s_idx_ff[STAGES-1];
         rsp_element_ff <= merged;
         rsp_last_ff    <= (s_idx_ff[STAGES-1] == IDX_W'(CELLS - 1));
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_product_index   = rsp_index_ff;
   assign rsp_product_element = rsp_element_ff;
   assign rsp_last_of_run     = rsp_last_ff;

   `MM4_ASSERT_NEXT(a_run_starts, req_fire && req_element_index == IDX_W'(CELLS - 1), run_ff && cnt_ff == '0)
   `MM4_ASSERT_NEXT(a_run_ends, run_ff && advance && cnt_ff == IDX_W'(CELLS - 1), !run_ff)
   `MM4_ASSERT_IMPL(a_last_tag, rsp_valid_ff, rsp_last_ff == (rsp_index_ff == IDX_W'(CELLS - 1)))
   `MM4_ASSERT_NEXT(a_stall_holds, !advance, $stable(s_vld_ff) && $stable(cnt_ff))
endmodule

/* tb/testbench.sv */
// Self-checking testbench of the 4x4 Q16.16 matrix multiply unit.
// Depends on mm4_pkg and the matrix4x4_multiply_unit RTL with its lane and merge modules.
`timescale 1ns / 1ps
module testbench;
   import mm4_pkg::*;

   localparam int unsigned LAST_INDEX     = CELLS - 1;
   localparam int unsigned FRAC           = FRAC_BITS_DEFAULT;
   localparam int unsigned LOAD_TARGET    = 500;
   localparam int unsigned CALM_FROM      = 420;
   localparam int unsigned DRAIN_AT       = 250;
   localparam int unsigned SETTLE_CYCLES  = 20;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam logic signed [PROD_W+1:0] ELEM_MAX = 66'sd2147483647;
   localparam logic signed [PROD_W+1:0] ELEM_MIN = -66'sd2147483648;

   typedef enum int unsigned {
      SMALL_VALUES, MEDIUM_VALUES, FULL_VALUES, CORNER_VALUES, MIXED_VALUES
   } value_range_type;

   typedef enum int unsigned {IN_ORDER, SHUFFLED, PARTIAL, STRAY} load_order_type;

   typedef struct {
      logic [IDX_W-1:0]         product_index;
      logic signed [ELEM_W-1:0] element;
      logic                     last_of_run;
   } product_beat_type;

   // Mirror of both element stores plus the queue of product beats still owed.
   class product_tracker;
      logic signed [ELEM_W-1:0] left_store[CELLS];
      logic signed [ELEM_W-1:0] right_store[CELLS];
      product_beat_type         expected_products[$];
      int unsigned              mismatches;
      int unsigned              products_checked;
      int unsigned              runs;

      function new();
         foreach (left_store[n]) begin
            left_store[n]  = '0;
            right_store[n] = '0;
         end
         mismatches       = 0;
         products_checked = 0;
         runs             = 0;
      endfunction

      // Exact sum of four products, floor shift, then saturation to 32 bits.
      function logic signed [ELEM_W-1:0] dot_product(int unsigned row, int unsigned col);
         logic signed [PROD_W+1:0] acc;
         logic signed [PROD_W-1:0] term;
         logic signed [PROD_W+1:0] scaled;
         int unsigned              k;
         acc = '0;
         for (k = 0; k < DIM; k++) begin
            term = left_store[row + DIM * k] * right_store[DIM * col + k];
            acc  = acc + term;
         end
         scaled = acc >>> FRAC;
         if (scaled > ELEM_MAX) return 32'h7FFF_FFFF;
         if (scaled < ELEM_MIN) return 32'h8000_0000;
         return scaled[ELEM_W-1:0];
      endfunction

      // An accepted load beat writes both stores; the last index owes a full run.
      function void note_load(logic [IDX_W-1:0] idx, logic signed [ELEM_W-1:0] l,
                              logic signed [ELEM_W-1:0] r);
         product_beat_type beat;
         int unsigned      n;
         left_store[idx]  = l;
         right_store[idx] = r;
         if (idx == LAST_INDEX) begin
            runs++;
            for (n = 0; n < CELLS; n++) begin
               beat.product_index = n[IDX_W-1:0];
               beat.element       = dot_product(n / DIM, n % DIM);
               beat.last_of_run   = (n == LAST_INDEX);
               expected_products.push_back(beat);
            end
         end
      endfunction

      function void check_product(logic [IDX_W-1:0] idx, logic signed [ELEM_W-1:0] elem,
                                  logic last);
         product_beat_type beat;
         products_checked++;
         if (expected_products.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected product beat, index %0d element %h last %b",
                     $time, idx, elem, last);
            return;
         end
         beat = expected_products.pop_front();
         if (idx !== beat.product_index) begin
            mismatches++;
            $display("%0t: product_index expected %0d actual %0d",
                     $time, beat.product_index, idx);
         end
         if (elem !== beat.element) begin
            mismatches++;
            $display("%0t: product_element at index %0d expected %h actual %h",
                     $time, beat.product_index, beat.element, elem);
         end
         if (last !== beat.last_of_run) begin
            mismatches++;
            $display("%0t: last_of_run at index %0d expected %b actual %b",
                     $time, beat.product_index, beat.last_of_run, last);
         end
      endfunction

      function int unsigned pending();
         return expected_products.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [IDX_W-1:0]         req_element_index = '0;
   logic signed [ELEM_W-1:0] req_left_element = '0;
   logic signed [ELEM_W-1:0] req_right_element = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [IDX_W-1:0]         rsp_product_index;
   logic signed [ELEM_W-1:0] rsp_product_element;
   logic                     rsp_last_of_run;

   product_tracker tracker = new();
   int unsigned    loads_sent = 0;
   int unsigned    rsp_hold = 0;
   int unsigned    quiet_cycles = 0;
   bit             idling_on = 1'b1;

   matrix4x4_multiply_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_element_index   (req_element_index),
      .req_left_element    (req_left_element),
      .req_right_element   (req_right_element),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_product_index   (rsp_product_index),
      .rsp_product_element (rsp_product_element),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Check product beats as they are taken and stall the result side in bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            tracker.check_product(rsp_product_index, rsp_product_element, rsp_last_of_run);
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= rsp_hold - 1;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            rsp_hold  <= $urandom_range(0, 6);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Count cycles in which no beat moves on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
   end

   function automatic logic signed [ELEM_W-1:0] random_element(value_range_type mode);
      value_range_type pick;
      pick = (mode == MIXED_VALUES) ? value_range_type'($urandom_range(0, 3)) : mode;
      case (pick)
         SMALL_VALUES: begin
            return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
         end
         MEDIUM_VALUES: begin
            return 32'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
         end
         CORNER_VALUES: begin
            case ($urandom_range(0, 5))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               4: return 32'h0001_0000;
               default: return 32'hFFFF_0000;
            endcase
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Present one load beat, hold it until taken, then maybe pause the sender.
   task automatic drive_load(input logic [IDX_W-1:0] idx, input logic signed [ELEM_W-1:0] l,
                             input logic signed [ELEM_W-1:0] r);
      req_valid         <= 1'b1;
      req_element_index <= idx;
      req_left_element  <= l;
      req_right_element <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_load(idx, l, r);
      loads_sent++;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Hold the sender off until every owed product beat has been taken.
   task automatic wait_for_products;
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   // One load sequence of the given shape with values from one range, or mixed ranges.
   task automatic load_sequence(load_order_type shape, value_range_type mode);
      int unsigned order[LAST_INDEX];
      int unsigned n;
      int unsigned j;
      int unsigned swap;
      int unsigned count;
      for (n = 0; n < LAST_INDEX; n++) order[n] = n;
      case (shape)
         IN_ORDER: begin
            for (n = 0; n < CELLS; n++)
               drive_load(n[IDX_W-1:0], random_element(mode), random_element(mode));
         end
         SHUFFLED: begin
            for (n = LAST_INDEX - 1; n > 0; n--) begin
               j        = $urandom_range(0, n);
               swap     = order[n];
               order[n] = order[j];
               order[j] = swap;
            end
            for (n = 0; n < LAST_INDEX; n++)
               drive_load(order[n][IDX_W-1:0], random_element(mode), random_element(mode));
            drive_load(LAST_INDEX[IDX_W-1:0], random_element(mode), random_element(mode));
         end
         PARTIAL: begin
            count = $urandom_range(0, 6);
            for (n = 0; n < count; n++)
               drive_load(IDX_W'($urandom_range(0, LAST_INDEX - 1)),
                          random_element(mode), random_element(mode));
            drive_load(LAST_INDEX[IDX_W-1:0], random_element(mode), random_element(mode));
         end
         default: begin
            count = $urandom_range(1, 5);
            for (n = 0; n < count; n++)
               drive_load(IDX_W'($urandom_range(0, LAST_INDEX)),
                          random_element(mode), random_element(mode));
         end
      endcase
   endtask

   initial begin
      int unsigned n;
      int unsigned pick;
      bit          drained_mid;
      drained_mid = 1'b0;
      reset <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Last index straight after reset computes from the cleared stores.
      drive_load(LAST_INDEX[IDX_W-1:0], 32'h8000_0000, 32'h8000_0000);
      // Full load of opposite extremes drives every sum to negative saturation.
      for (n = 0; n < CELLS; n++)
         drive_load(n[IDX_W-1:0], 32'h7FFF_FFFF, 32'h8000_0000);
      // Repeated and out-of-order indices over leftovers of the previous load.
      drive_load(IDX_W'(0), 32'h0001_0000, 32'h0001_0000);
      drive_load(IDX_W'(0), 32'hFFFF_0000, 32'h0001_0000);
      drive_load(IDX_W'(10), 32'h0000_0000, 32'hFFFF_FFFF);
      drive_load(IDX_W'(5), 32'h0000_0001, 32'hFFFF_FFFF);
      drive_load(LAST_INDEX[IDX_W-1:0], 32'h0001_0000, 32'h0001_0000);

      // Random part: mostly well-formed loads, some partial and stray beats.
      while (loads_sent < LOAD_TARGET) begin
         if (!drained_mid && loads_sent >= DRAIN_AT) begin
            wait_for_products();
            drained_mid = 1'b1;
         end
         idling_on = (loads_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         load_sequence(pick < 50 ? IN_ORDER : pick < 70 ? SHUFFLED :
                       pick < 85 ? PARTIAL : STRAY,
                       value_range_type'($urandom_range(0, 4)));
      end

      wait_for_products();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Run covered %0d load beats, %0d product runs and %0d product beats,",
               loads_sent, tracker.runs, tracker.products_checked);
      $display("with reset-state, partial, shuffled and saturating loads; %0d mismatches.",
               tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule
